/* hdl/lrupr_pkg.sv */
// lrupr_pkg: constants and types shared by the lru page replacement block
// and its checker. No dependencies.
`default_nettype none

package lrupr_pkg;

	localparam int MAX_WAYS   = 16;
	localparam int PAGE_COUNT = 255;

	localparam int PAGE_W  = 8;
	localparam int CAP_W   = 5;
	localparam int OCC_W   = $clog2(MAX_WAYS + 1);
	localparam int IDX_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int MISS_W  = 16;
	localparam int MAP_D   = PAGE_COUNT + 1;

	localparam logic [MISS_W-1:0] MISS_MAX = '1;

	typedef logic [PAGE_W-1:0] page_t;
	typedef logic [OCC_W-1:0]  occ_t;
	typedef logic [IDX_W-1:0]  idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SCAN,
		ST_INSERT,
		ST_DONE
	} state_t;

	// capacity zero acts as one, above the way count acts as the way count
	function automatic occ_t eff_capacity(input logic [CAP_W-1:0] cap);
		occ_t c;
		if (cap == '0) begin
			c = OCC_W'(1);
		end else if (32'(cap) > MAX_WAYS) begin
			c = OCC_W'(MAX_WAYS);
		end else begin
			c = OCC_W'(cap);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* hdl/lru_page_replacement.sv */
// lru_page_replacement: fully associative lru cache over page numbers.
// Uses lrupr_pkg for constants, the state type and the capacity clamp.
//
// Usage:
//   Requests enter on in_valid/in_stall with page, first_access and
//   last_access; one result leaves on out_valid/out_stall for each request.
//   A request is taken while the block is idle. One shared compare unit walks
//   the recency list one entry per cycle: a search pass tells hit from miss,
//   then for a hit or an evicting miss a second pass drops that entry (or the
//   least recent one) and closes the gap behind it.
//   A hit or an evicting miss takes both passes; a miss that only fills
//   takes at most the search pass; a page of zero skips the list. The
//   result register loads as the block goes back to idle.
//   The next request is taken in idle even while the previous result still
//   waits under out_stall; a finished result then holds inside the block
//   until the output register frees. Capacity is written on cfg_valid/cfg_ready;
//   the user must write it only while idle, as the block does not enforce
//   it; cfg_ready is always high.
//   Reset (arst_n low) empties the cache, clears the miss count and sets
//   capacity to 16; no clearing pass is needed.
`default_nettype none

module lru_page_replacement (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire [lrupr_pkg::CAP_W-1:0] cfg_capacity,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire [lrupr_pkg::PAGE_W-1:0] page,
	input  wire                        first_access,
	input  wire                        last_access,
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic                       hit,
	output logic                       evict_valid,
	output logic [lrupr_pkg::PAGE_W-1:0] evicted_page,
	output logic [lrupr_pkg::MISS_W-1:0] miss_count,
	output logic                       trace_end
);
	import lrupr_pkg::*;

	state_t              state_q, state_d;
	logic [CAP_W-1:0]    cap_q;
	page_t               list_q [MAX_WAYS];
	occ_t                occ_q;
	logic [MISS_W-1:0]   miss_q;

	page_t               page_q;
	logic                last_q;
	logic                hit_q;
	logic                evict_q;
	logic                found_q;
	page_t               victim_q;
	idx_t                idx_q;

	logic                in_acc;
	logic                out_free;
	logic                page_ok;
	occ_t                occ_now;
	page_t               rd_data;
	logic                page_eq;
	logic                seen_hit;
	logic                evict_now;
	logic                match;
	logic                scan_last;
	logic                wr_en;
	idx_t                wr_idx;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;

	// decisions at acceptance, after a possible cold start
	assign page_ok  = (page != '0) && (32'(page) <= PAGE_COUNT);
	assign occ_now  = first_access ? '0 : occ_q;

	// shared compare unit over the recency list
	assign rd_data   = list_q[idx_q];
	assign page_eq   = (rd_data == page_q);
	assign seen_hit  = hit_q || page_eq;
	assign evict_now = !seen_hit && (occ_q >= eff_capacity(cap_q));
	assign match     = !found_q && (evict_q ? (idx_q == '0) : page_eq);
	assign scan_last = ({1'b0, idx_q} == OCC_W'(occ_q - OCC_W'(1)));

	always_comb begin
		state_d = state_q;
		wr_en   = 1'b0;
		wr_idx  = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (!page_ok) begin
						state_d = ST_DONE;
					end else if (occ_now == '0) begin
						state_d = ST_INSERT;
					end else begin
						state_d = ST_SEARCH;
					end
				end
			end
			ST_SEARCH: begin
				if (scan_last) begin
					state_d = (seen_hit || evict_now) ? ST_SCAN : ST_INSERT;
				end
			end
			ST_SCAN: begin
				if (found_q) begin
					wr_en  = 1'b1;
					wr_idx = idx_q - IDX_W'(1);
				end
				if (scan_last) begin
					state_d = ST_INSERT;
				end
			end
			ST_INSERT: begin
				wr_en   = 1'b1;
				wr_idx  = (hit_q || evict_q) ? IDX_W'(occ_q - OCC_W'(1)) : IDX_W'(occ_q);
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_capacity;
		end
	end

	// cache state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q     <= '0;
			miss_q    <= '0;
			found_q   <= 1'b0;
			idx_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						found_q <= 1'b0;
						idx_q   <= '0;
						if (first_access) begin
							occ_q  <= '0;
							miss_q <= page_ok ? MISS_W'(1) : '0;
						end else if (page_ok && (occ_q == '0) && (miss_q != MISS_MAX)) begin
							miss_q <= miss_q + MISS_W'(1);
						end
					end
				end
				ST_SEARCH: begin
					idx_q <= scan_last ? '0 : idx_q + IDX_W'(1);
					if (scan_last && !seen_hit && (miss_q != MISS_MAX)) begin
						miss_q <= miss_q + MISS_W'(1);
					end
				end
				ST_SCAN: begin
					if (match) begin
						found_q <= 1'b1;
					end
					idx_q <= idx_q + IDX_W'(1);
				end
				ST_INSERT: begin
					if (!hit_q && !evict_q) begin
						occ_q <= occ_q + OCC_W'(1);
					end
				end
				ST_DONE: ;
				default: ;
			endcase
		end
	end

	// request payload and per-request flags
	always_ff @(posedge clk) begin
		if (in_acc) begin
			page_q   <= page;
			last_q   <= last_access;
			hit_q    <= 1'b0;
			evict_q  <= 1'b0;
			victim_q <= '0;
		end else if (state_q == ST_SEARCH) begin
			if (page_eq) begin
				hit_q <= 1'b1;
			end
			if (scan_last && evict_now) begin
				evict_q <= 1'b1;
			end
		end else if ((state_q == ST_SCAN) && match && evict_q) begin
			victim_q <= rd_data;
		end
	end

	// recency list, entry 0 least recent
	always_ff @(posedge clk) begin
		if (wr_en) begin
			list_q[wr_idx] <= (state_q == ST_SCAN) ? rd_data : page_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			hit          <= hit_q;
			evict_valid  <= evict_q;
			evicted_page <= victim_q;
			miss_count   <= miss_q;
			trace_end    <= last_q;
		end
	end

endmodule

`default_nettype wire

/* hdl/lrupr_checker.sv */
// lrupr_checker: port-level assertions for lru_page_replacement, bound to it.
// Uses lrupr_pkg for field widths.
`default_nettype none

module lrupr_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          in_valid,
	input wire                          in_stall,
	input wire                          out_valid,
	input wire                          out_stall,
	input wire                          hit,
	input wire                          evict_valid,
	input wire [lrupr_pkg::PAGE_W-1:0]  evicted_page,
	input wire [lrupr_pkg::MISS_W-1:0]  miss_count
);
	import lrupr_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(evicted_page) && $stable(miss_count))
		else $error("stalled result changed");

	// no victim reported without an eviction
	a_no_victim: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !evict_valid |-> evicted_page == '0)
		else $error("evicted page set without eviction");

	// a hit never evicts
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> !evict_valid)
		else $error("hit reported an eviction");

	// block is busy right after taking a request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while still working");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.hit          (hit),
	.evict_valid  (evict_valid),
	.evicted_page (evicted_page),
	.miss_count   (miss_count)
);

`default_nettype wire

/* test/tb_top.sv */
// tb_top: self-checking bench for lru_page_replacement, directed, back-pressure
// and random trace tests against an in-bench lru model.
// Depends on lrupr_pkg and the lru_page_replacement rtl.
`default_nettype none

module tb_top;
	import lrupr_pkg::*;

	typedef struct packed {
		logic              hit;
		logic              evict_valid;
		page_t             evicted_page;
		logic [MISS_W-1:0] miss_count;
		logic              trace_end;
	} access_result_t;

	localparam int RANDOM_ACCESSES = 780;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CAP_W-1:0]  cfg_capacity;
	logic              in_valid;
	logic              in_stall;
	page_t             page;
	logic              first_access;
	logic              last_access;
	logic              out_valid;
	logic              out_stall;
	logic              hit;
	logic              evict_valid;
	page_t             evicted_page;
	logic [MISS_W-1:0] miss_count;
	logic              trace_end;

	// bench copy of the cache
	logic [MAP_D-1:0]  cached_pages;
	page_t             lru_order [MAX_WAYS];
	int                lru_fill;
	logic [MISS_W-1:0] miss_total;
	logic [CAP_W-1:0]  capacity_reg;
	access_result_t    expected_results [$];
	access_result_t    want;

	int fail_count;
	int accesses_sent;
	int hold_cycles = 0;
	int hold_request = 0;
	bit hold_taken = 1'b0;
	int stall_left = 0;
	bit sender_quiet;
	bit receiver_quiet;

	lru_page_replacement DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_capacity (cfg_capacity),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.page         (page),
		.first_access (first_access),
		.last_access  (last_access),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.hit          (hit),
		.evict_valid  (evict_valid),
		.evicted_page (evicted_page),
		.miss_count   (miss_count),
		.trace_end    (trace_end)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end
		if (r < 88) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 30);
	endfunction

	function automatic void cache_cold_start();
		cached_pages = '0;
		lru_fill = 0;
		miss_total = '0;
		foreach (lru_order[i]) begin
			lru_order[i] = '0;
		end
	endfunction

	function automatic int cache_limit();
		if (capacity_reg == '0) begin
			return 1;
		end
		if (int'(capacity_reg) > MAX_WAYS) begin
			return MAX_WAYS;
		end
		return int'(capacity_reg);
	endfunction

	function automatic void remove_entry(int pos);
		for (int i = pos; i + 1 < lru_fill; i++) begin
			lru_order[i] = lru_order[i + 1];
		end
		if (lru_fill > 0) begin
			lru_fill--;
		end
	endfunction

	function automatic void predict_access(page_t pg, logic first, logic last);
		access_result_t r;
		int pos;
		r = '0;
		r.trace_end = last;
		if (first) begin
			cache_cold_start();
		end
		if (pg != '0 && int'(pg) <= PAGE_COUNT) begin
			if (cached_pages[pg]) begin
				r.hit = 1'b1;
				pos = -1;
				for (int i = 0; i < lru_fill; i++) begin
					if (pos < 0 && lru_order[i] == pg) begin
						pos = i;
					end
				end
				if (pos >= 0) begin
					remove_entry(pos);
					lru_order[lru_fill] = pg;
					lru_fill++;
				end
			end else begin
				if (miss_total != MISS_MAX) begin
					miss_total = miss_total + MISS_W'(1);
				end
				if (lru_fill >= cache_limit() && lru_fill > 0) begin
					r.evict_valid = 1'b1;
					r.evicted_page = lru_order[0];
					cached_pages[lru_order[0]] = 1'b0;
					remove_entry(0);
				end
				if (lru_fill < MAX_WAYS) begin
					lru_order[lru_fill] = pg;
					lru_fill++;
					cached_pages[pg] = 1'b1;
				end
			end
		end
		r.miss_count = miss_total;
		expected_results.push_back(r);
	endfunction

	function automatic void report_mismatch(string field, logic [31:0] want_val,
			logic [31:0] got_val);
		fail_count++;
		$error("%s: expected %0h, got %0h", field, want_val, got_val);
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_access(page_t pg, logic first, logic last);
		int gap;
		gap = sender_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		page <= pg;
		first_access <= first;
		last_access <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_access(pg, first, last);
		accesses_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_capacity <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		capacity_reg = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// receiver side: random stalls plus an optional long hold-off
	always @(negedge clk) begin
		if (!hold_taken && hold_request > 0) begin
			hold_cycles = hold_request;
			hold_taken = 1'b1;
		end
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles = hold_cycles - 1;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			if (!receiver_quiet && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("out_valid", 32'd0, 32'd1);
			end else begin
				want = expected_results.pop_front();
				if (hit !== want.hit) begin
					report_mismatch("hit", 32'(want.hit), 32'(hit));
				end
				if (evict_valid !== want.evict_valid) begin
					report_mismatch("evict_valid", 32'(want.evict_valid), 32'(evict_valid));
				end
				if (evicted_page !== want.evicted_page) begin
					report_mismatch("evicted_page", 32'(want.evicted_page),
						32'(evicted_page));
				end
				if (miss_count !== want.miss_count) begin
					report_mismatch("miss_count", 32'(want.miss_count), 32'(miss_count));
				end
				if (trace_end !== want.trace_end) begin
					report_mismatch("trace_end", 32'(want.trace_end), 32'(trace_end));
				end
			end
		end
	end

	task automatic test_directed_basics();
		send_access(8'd5, 1'b0, 1'b0);
		send_access(8'd255, 1'b0, 1'b0);
		send_access(8'd1, 1'b0, 1'b0);
		send_access(8'd5, 1'b0, 1'b0);
		// out of range page is ignored
		send_access(8'd0, 1'b0, 1'b0);
		send_access(8'd128, 1'b0, 1'b1);
		// ignored page still empties the cache on first access
		send_access(8'd0, 1'b1, 1'b0);
		send_access(8'd5, 1'b0, 1'b0);
		send_access(8'd5, 1'b0, 1'b0);
		send_access(8'd170, 1'b1, 1'b0);
		send_access(8'd85, 1'b0, 1'b1);
	endtask

	task automatic test_zero_capacity();
		write_capacity(5'd0);
		send_access(8'd10, 1'b1, 1'b0);
		send_access(8'd20, 1'b0, 1'b0);
		send_access(8'd20, 1'b0, 1'b0);
		send_access(8'd10, 1'b0, 1'b1);
	endtask

	task automatic test_backpressure();
		write_capacity(5'd16);
		sender_quiet = 1'b1;
		receiver_quiet = 1'b1;
		hold_request = 250;
		for (int i = 0; i < 30; i++) begin
			send_access(page_t'($urandom_range(1, 12)), 1'b0, i == 29);
		end
		sender_quiet = 1'b0;
		receiver_quiet = 1'b0;
	endtask

	task automatic test_random_traces();
		page_t working_set [24];
		int    set_size;
		int    trace_len;
		int    trace_no;
		int    start_count;
		int    r;
		bit    fresh;
		page_t pg;
		logic  first;
		logic  last;
		trace_no = 0;
		start_count = accesses_sent;
		while (accesses_sent < start_count + RANDOM_ACCESSES) begin
			case (trace_no)
				0: write_capacity(5'd0);
				1: write_capacity(5'd1);
				2: write_capacity(5'd31);
				3: write_capacity(5'd16);
				4: write_capacity(5'd17);
				5: write_capacity(5'd3);
				default: begin
					if ($urandom_range(0, 1) == 0) begin
						write_capacity(CAP_W'($urandom_range(0, 31)));
					end
				end
			endcase
			sender_quiet = ($urandom_range(0, 4) == 0);
			receiver_quiet = ($urandom_range(0, 4) == 0);
			set_size = $urandom_range(1, 24);
			for (int i = 0; i < set_size; i++) begin
				working_set[i] = page_t'($urandom_range(1, 255));
			end
			trace_len = $urandom_range(8, 60);
			// some traces carry the cache over, so a lowered capacity bites
			fresh = ($urandom_range(0, 9) < 7);
			for (int i = 0; i < trace_len; i++) begin
				r = $urandom_range(0, 99);
				if (r < 84) begin
					pg = working_set[$urandom_range(0, set_size - 1)];
				end else if (r < 96) begin
					pg = page_t'($urandom_range(1, 255));
				end else begin
					pg = '0;
				end
				first = (i == 0 && fresh) || ($urandom_range(0, 49) == 0);
				last = (i == trace_len - 1) || ($urandom_range(0, 29) == 0);
				send_access(pg, first, last);
			end
			trace_no++;
		end
		sender_quiet = 1'b0;
		receiver_quiet = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_capacity = '0;
		in_valid = 1'b0;
		page = '0;
		first_access = 1'b0;
		last_access = 1'b0;
		sender_quiet = 1'b0;
		receiver_quiet = 1'b0;
		fail_count = 0;
		accesses_sent = 0;
		cache_cold_start();
		capacity_reg = 5'd16;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed_basics();
		test_zero_capacity();
		test_backpressure();
		test_random_traces();

		drain_results();
		repeat (30) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

`default_nettype wire
